[hdl/hamming_descriptor_matcher_top_defines.svh]
// Assertion macros shared by the matcher checker
`ifndef HAMMING_DESCRIPTOR_MATCHER_TOP_DEFINES_SVH
`define HAMMING_DESCRIPTOR_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define HDM_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("matcher port check failed");

// next-cycle implication
`define HDM_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("matcher port check failed");

`endif

[hdl/hdm_pkg.sv]
// Shared types, codes and helpers of the Hamming descriptor matcher
package hdm_pkg;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LDQ   = 2'd1;
   localparam logic [1:0] MODE_LDT   = 2'd2;
   localparam logic [1:0] MODE_RUN   = 2'd3;

   localparam logic [1:0] CSR_MAX_DIST = 2'd0;
   localparam logic [1:0] CSR_RATIO    = 2'd1;
   localparam logic [1:0] CSR_XCHK     = 2'd2;

   localparam int DIST_W = 9;
   localparam int WORD_W = 64;
   localparam int POP_W  = 7;
   localparam int THR_W  = 10;
   localparam int PROD_W = DIST_W + THR_W;
   localparam int OIDX_W = 6;

   localparam logic [DIST_W-1:0] DIST_NONE = 9'd257;
   localparam logic [DIST_W-1:0] DIST_TOP  = 9'd256;
   localparam logic [1:0]        WORD_LAST = 2'd3;

   typedef struct packed {
      logic ld_query;
      logic ld_train;
      logic run_init;
      logic dist_acc;
      logic dist_cmp;
      logic best_init;
      logic qres_wr;
      logic tb_clr;
      logic xchk_upd;
      logic ratio_mul;
      logic flag_wr;
      logic emit_chk;
      logic emit_end;
      logic train_multi;
   } hdm_cmd_type;

   typedef struct packed {
      logic out_stall;
   } hdm_sts_type;

   function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
      logic [POP_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         n = n + POP_W'(v[i]);
      end
      return n;
   endfunction

endpackage

[hdl/hdm_ram.sv]
// Generic single-write, single-read RAM with registered read data
module hdm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hdm_ctrl.sv]
// Sequencer: load handling and the run's pass order over queries and train entries
module hdm_ctrl #(
   parameter int MAX_QUERY = 64,
   parameter int MAX_TRAIN = 64,
   parameter int QIW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1,
   parameter int TIW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [1:0]          req_word_index,
   input  hdm_pkg::hdm_sts_type sts,
   output hdm_pkg::hdm_cmd_type cmd,
   output logic [QIW-1:0]      q_idx,
   output logic [TIW-1:0]      t_idx,
   output logic [1:0]          w_idx,
   output logic [8:0]          d_val
);
   import hdm_pkg::*;

   localparam int QCW = $clog2(MAX_QUERY + 1);
   localparam int TCW = $clog2(MAX_TRAIN + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DRD  = 4'd1;
   localparam logic [3:0] S_DACC = 4'd2;
   localparam logic [3:0] S_DCMP = 4'd3;
   localparam logic [3:0] S_QWR  = 4'd4;
   localparam logic [3:0] S_TCLR = 4'd5;
   localparam logic [3:0] S_XW1  = 4'd6;
   localparam logic [3:0] S_XW2  = 4'd7;
   localparam logic [3:0] S_XUPD = 4'd8;
   localparam logic [3:0] S_FW1  = 4'd9;
   localparam logic [3:0] S_FW2  = 4'd10;
   localparam logic [3:0] S_FMUL = 4'd11;
   localparam logic [3:0] S_FWR  = 4'd12;
   localparam logic [3:0] S_EW1  = 4'd13;
   localparam logic [3:0] S_EW2  = 4'd14;
   localparam logic [3:0] S_EEND = 4'd15;

   logic [3:0]     state_ff, state_in;
   logic [QIW-1:0] q_ff, q_in;
   logic [TIW-1:0] t_ff, t_in;
   logic [1:0]     w_ff, w_in;
   logic [8:0]     d_ff, d_in;
   logic [QCW-1:0] qc_ff, qc_in;
   logic [TCW-1:0] tc_ff, tc_in;
   logic           q_last, t_last;

   assign q_last = ((QCW'(q_ff) + QCW'(1)) == qc_ff);
   assign t_last = ((TCW'(t_ff) + TCW'(1)) == tc_ff);

   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      t_in     = t_ff;
      w_in     = w_ff;
      d_in     = d_ff;
      qc_in    = qc_ff;
      tc_in    = tc_ff;
      cmd      = '0;
      cmd.train_multi = (tc_ff >= TCW'(2));
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_CLEAR: begin
                     qc_in = '0;
                     tc_in = '0;
                  end
                  MODE_LDQ: begin
                     if (qc_ff < QCW'(MAX_QUERY)) begin
                        cmd.ld_query = 1'b1;
                        if (req_word_index == WORD_LAST) qc_in = qc_ff + QCW'(1);
                     end
                  end
                  MODE_LDT: begin
                     if (tc_ff < TCW'(MAX_TRAIN)) begin
                        cmd.ld_train = 1'b1;
                        if (req_word_index == WORD_LAST) tc_in = tc_ff + TCW'(1);
                     end
                  end
                  MODE_RUN: begin
                     cmd.run_init = 1'b1;
                     q_in = '0;
                     t_in = '0;
                     w_in = '0;
                     if (qc_ff == '0 || tc_ff == '0) state_in = S_EEND;
                     else state_in = S_DRD;
                  end
                  default: ;
               endcase
            end
         end
         S_DRD: state_in = S_DACC;
         S_DACC: begin
            cmd.dist_acc = 1'b1;
            w_in = w_ff + 2'd1;
            state_in = (w_ff == WORD_LAST) ? S_DCMP : S_DRD;
         end
         S_DCMP: begin
            cmd.dist_cmp = 1'b1;
            if (t_last) begin
               state_in = S_QWR;
            end else begin
               t_in = t_ff + TIW'(1);
               state_in = S_DRD;
            end
         end
         S_QWR: begin
            cmd.qres_wr   = 1'b1;
            cmd.best_init = 1'b1;
            t_in = '0;
            if (q_last) begin
               q_in = '0;
               state_in = S_TCLR;
            end else begin
               q_in = q_ff + QIW'(1);
               state_in = S_DRD;
            end
         end
         S_TCLR: begin
            cmd.tb_clr = 1'b1;
            if (t_last) begin
               t_in = '0;
               state_in = S_XW1;
            end else begin
               t_in = t_ff + TIW'(1);
            end
         end
         S_XW1: state_in = S_XW2;
         S_XW2: state_in = S_XUPD;
         S_XUPD: begin
            cmd.xchk_upd = 1'b1;
            if (q_last) begin
               q_in = '0;
               state_in = S_FW1;
            end else begin
               q_in = q_ff + QIW'(1);
               state_in = S_XW1;
            end
         end
         S_FW1: state_in = S_FW2;
         S_FW2: state_in = S_FMUL;
         S_FMUL: begin
            cmd.ratio_mul = 1'b1;
            state_in = S_FWR;
         end
         S_FWR: begin
            cmd.flag_wr = 1'b1;
            if (q_last) begin
               q_in = '0;
               d_in = '0;
               state_in = S_EW1;
            end else begin
               q_in = q_ff + QIW'(1);
               state_in = S_FW1;
            end
         end
         S_EW1: state_in = S_EW2;
         S_EW2: begin
            cmd.emit_chk = 1'b1;
            if (!sts.out_stall) begin
               if (q_last) begin
                  q_in = '0;
                  if (d_ff == DIST_TOP) begin
                     state_in = S_EEND;
                  end else begin
                     d_in = d_ff + 9'd1;
                     state_in = S_EW1;
                  end
               end else begin
                  q_in = q_ff + QIW'(1);
                  state_in = S_EW1;
               end
            end
         end
         S_EEND: begin
            cmd.emit_end = 1'b1;
            if (!sts.out_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         qc_ff    <= '0;
         tc_ff    <= '0;
         q_ff     <= '0;
         t_ff     <= '0;
         w_ff     <= '0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         qc_ff    <= qc_in;
         tc_ff    <= tc_in;
         q_ff     <= q_in;
         t_ff     <= t_in;
         w_ff     <= w_in;
         d_ff     <= d_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   // while idle the store address follows the fill count and the incoming word
   assign q_idx = (state_ff == S_IDLE) ? qc_ff[QIW-1:0] : q_ff;
   assign t_idx = (state_ff == S_IDLE) ? tc_ff[TIW-1:0] : t_ff;
   assign w_idx = (state_ff == S_IDLE) ? req_word_index : w_ff;
   assign d_val = d_ff;

endmodule

[hdl/hdm_dp.sv]
// Datapath: descriptor stores, distance unit, per-query results, cross-check and output
module hdm_dp #(
   parameter int MAX_QUERY = 64,
   parameter int MAX_TRAIN = 64,
   parameter int QIW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1,
   parameter int TIW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_data,
   input  logic [63:0]          req_word_data,
   input  hdm_pkg::hdm_cmd_type cmd,
   output hdm_pkg::hdm_sts_type sts,
   input  logic [QIW-1:0]       q_idx,
   input  logic [TIW-1:0]       t_idx,
   input  logic [1:0]           w_idx,
   input  logic [8:0]           d_val,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [5:0]           rsp_query_index,
   output logic [5:0]           rsp_train_index,
   output logic [8:0]           rsp_distance,
   output logic                 rsp_match_valid,
   output logic                 rsp_last
);
   import hdm_pkg::*;

   localparam int QSA_W = $clog2(MAX_QUERY * 4);
   localparam int TSA_W = $clog2(MAX_TRAIN * 4);
   localparam int QRW   = 1 + 2 * DIST_W + TIW;
   localparam int TBW   = 1 + QIW + DIST_W;

   // configuration
   logic [DIST_W-1:0] maxd_ff;
   logic [THR_W-1:0]  thr_ff;
   logic              xchk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         maxd_ff <= 9'd64;
         thr_ff  <= '0;
         xchk_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_DIST: maxd_ff <= csr_data[DIST_W-1:0];
            CSR_RATIO:    thr_ff  <= csr_data;
            CSR_XCHK:     xchk_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // descriptor stores
   logic [WORD_W-1:0] qword, tword;

   hdm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_QUERY * 4), .AW(QSA_W)) u_qstore (
      .clock   (clock),
      .wr_en   (cmd.ld_query),
      .wr_addr (QSA_W'({q_idx, w_idx})),
      .wr_data (req_word_data),
      .rd_addr (QSA_W'({q_idx, w_idx})),
      .rd_data (qword)
   );

   hdm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TRAIN * 4), .AW(TSA_W)) u_tstore (
      .clock   (clock),
      .wr_en   (cmd.ld_train),
      .wr_addr (TSA_W'({t_idx, w_idx})),
      .wr_data (req_word_data),
      .rd_addr (TSA_W'({t_idx, w_idx})),
      .rd_data (tword)
   );

   // distance accumulation and best/second tracking
   logic [DIST_W-1:0] acc_ff, acc_in;
   logic [DIST_W-1:0] b_ff, b_in, s_ff, s_in;
   logic [TIW-1:0]    bi_ff, bi_in;

   always_comb begin
      acc_in = acc_ff;
      b_in   = b_ff;
      s_in   = s_ff;
      bi_in  = bi_ff;
      if (cmd.dist_acc) acc_in = acc_ff + DIST_W'(pop64(qword ^ tword));
      if (cmd.run_init || cmd.dist_cmp) acc_in = '0;
      if (cmd.dist_cmp) begin
         if (acc_ff < b_ff) begin
            s_in  = b_ff;
            b_in  = acc_ff;
            bi_in = t_idx;
         end else if (acc_ff < s_ff) begin
            s_in = acc_ff;
         end
      end
      if (cmd.run_init || cmd.best_init) begin
         b_in  = DIST_NONE;
         s_in  = DIST_NONE;
         bi_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      b_ff   <= b_in;
      s_ff   <= s_in;
      bi_ff  <= bi_in;
   end

   // per-query result store: {ok, best, second, best train}
   logic [QRW-1:0]    qrd, qwd;
   logic              qr_ok;
   logic [DIST_W-1:0] qr_b, qr_s;
   logic [TIW-1:0]    qr_bi;
   logic              flag_ok;

   assign qr_ok = qrd[QRW-1];
   assign qr_b  = qrd[QRW-2 -: DIST_W];
   assign qr_s  = qrd[TIW+DIST_W-1 -: DIST_W];
   assign qr_bi = qrd[TIW-1:0];
   assign qwd   = cmd.flag_wr ? {flag_ok, qr_b, qr_s, qr_bi} : {1'b0, b_ff, s_ff, bi_ff};

   hdm_ram #(.WIDTH(QRW), .DEPTH(MAX_QUERY), .AW(QIW)) u_qres (
      .clock   (clock),
      .wr_en   (cmd.qres_wr || cmd.flag_wr),
      .wr_addr (q_idx),
      .wr_data (qwd),
      .rd_addr (q_idx),
      .rd_data (qrd)
   );

   // per-train mutual best: {has, query, dist}
   logic [TBW-1:0]    tbrd, tbwd;
   logic              tb_has;
   logic [QIW-1:0]    tb_q;
   logic [DIST_W-1:0] tb_d;
   logic              tb_take;

   assign tb_has  = tbrd[TBW-1];
   assign tb_q    = tbrd[QIW+DIST_W-1 -: QIW];
   assign tb_d    = tbrd[DIST_W-1:0];
   assign tb_take = cmd.xchk_upd && (!tb_has || qr_b < tb_d);
   assign tbwd    = cmd.tb_clr ? '0 : {1'b1, q_idx, qr_b};

   hdm_ram #(.WIDTH(TBW), .DEPTH(MAX_TRAIN), .AW(TIW)) u_tbest (
      .clock   (clock),
      .wr_en   (cmd.tb_clr || tb_take),
      .wr_addr (cmd.tb_clr ? t_idx : qr_bi),
      .wr_data (tbwd),
      .rd_addr (qr_bi),
      .rd_data (tbrd)
   );

   // acceptance filter
   logic [PROD_W-1:0] prod_ff;
   logic              ratio_rej;

   always_ff @(posedge clock) begin
      if (cmd.ratio_mul) prod_ff <= PROD_W'(thr_ff) * PROD_W'(qr_s);
   end

   assign ratio_rej = (thr_ff != '0) && cmd.train_multi && (qr_s != '0) &&
                      ({2'b00, qr_b, 8'h00} >= prod_ff);
   assign flag_ok   = (qr_b <= maxd_ff) && !ratio_rej && !(xchk_ff && tb_q != q_idx);

   // one match is held back so the final one can carry last
   logic              pend_v_ff, pend_v_in;
   logic [QIW-1:0]    pend_q_ff;
   logic [TIW-1:0]    pend_t_ff;
   logic [DIST_W-1:0] pend_d_ff;
   logic              out_free, hit, take_hit, fin, load;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        rq_ff, rq_in, rt_ff, rt_in;
   logic [8:0]        rd_ff, rd_in;
   logic              rm_ff, rm_in, rl_ff, rl_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit      = qr_ok && (qr_b == d_val);
   assign sts.out_stall = (cmd.emit_chk && hit && pend_v_ff && !out_free) ||
                          (cmd.emit_end && !out_free);
   assign take_hit = cmd.emit_chk && hit && !sts.out_stall;
   assign fin      = cmd.emit_end && out_free;
   assign load     = (take_hit && pend_v_ff) || fin;

   always_comb begin
      pend_v_in = pend_v_ff;
      if (take_hit) pend_v_in = 1'b1;
      if (fin || cmd.run_init) pend_v_in = 1'b0;
      rq_in = rq_ff;
      rt_in = rt_ff;
      rd_in = rd_ff;
      rm_in = rm_ff;
      rl_in = rl_ff;
      if (load) begin
         rm_in = pend_v_ff;
         rl_in = fin;
         rq_in = pend_v_ff ? OIDX_W'(pend_q_ff) : '0;
         rt_in = pend_v_ff ? OIDX_W'(pend_t_ff) : '0;
         rd_in = pend_v_ff ? pend_d_ff : '0;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take_hit) begin
         pend_q_ff <= q_idx;
         pend_t_ff <= qr_bi;
         pend_d_ff <= qr_b;
      end
      rq_ff <= rq_in;
      rt_ff <= rt_in;
      rd_ff <= rd_in;
      rm_ff <= rm_in;
      rl_ff <= rl_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_query_index = rq_ff;
   assign rsp_train_index = rt_ff;
   assign rsp_distance    = rd_ff;
   assign rsp_match_valid = rm_ff;
   assign rsp_last        = rl_ff;

endmodule

[hdl/hamming_descriptor_matcher_top.sv]
// Load and clear requests are taken while idle; a new item is taken in the cycle after.
// A run over Q queries and T train entries steps through the four-word distance loop
// over the store read ports and the 257-level sorted emission sweep over the
// per-query result RAM.
// Synchronous active-high reset clears control, counts and configuration registers;
// descriptor and result RAM contents are not cleared.
module hamming_descriptor_matcher_top #(
   parameter int MAX_QUERY = 64,
   parameter int MAX_TRAIN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_word_index,
   input  logic [63:0] req_word_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_query_index,
   output logic [5:0]  rsp_train_index,
   output logic [8:0]  rsp_distance,
   output logic        rsp_match_valid,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import hdm_pkg::*;

   localparam int QIW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int TIW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;

   hdm_cmd_type    cmd;
   hdm_sts_type    sts;
   logic [QIW-1:0] q_idx;
   logic [TIW-1:0] t_idx;
   logic [1:0]     w_idx;
   logic [8:0]     d_val;

   assign csr_ready = 1'b1;

   hdm_ctrl #(.MAX_QUERY(MAX_QUERY), .MAX_TRAIN(MAX_TRAIN)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_word_index (req_word_index),
      .sts            (sts),
      .cmd            (cmd),
      .q_idx          (q_idx),
      .t_idx          (t_idx),
      .w_idx          (w_idx),
      .d_val          (d_val)
   );

   hdm_dp #(.MAX_QUERY(MAX_QUERY), .MAX_TRAIN(MAX_TRAIN)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_word_data   (req_word_data),
      .cmd             (cmd),
      .sts             (sts),
      .q_idx           (q_idx),
      .t_idx           (t_idx),
      .w_idx           (w_idx),
      .d_val           (d_val),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_query_index (rsp_query_index),
      .rsp_train_index (rsp_train_index),
      .rsp_distance    (rsp_distance),
      .rsp_match_valid (rsp_match_valid),
      .rsp_last        (rsp_last)
   );

endmodule

[hdl/hdm_checker.sv]
// Port-level checks for the matcher, bound to the top level
`include "hamming_descriptor_matcher_top_defines.svh"

module hdm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_query_index,
   input logic [5:0]  rsp_train_index,
   input logic [8:0]  rsp_distance,
   input logic        rsp_match_valid,
   input logic        rsp_last
);
   import hdm_pkg::*;

   `HDM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_distance) && $stable(rsp_query_index))
   `HDM_ASSERT_NOW(a_empty_last, rsp_valid && !rsp_match_valid, rsp_last)
   `HDM_ASSERT_NOW(a_empty_zero, rsp_valid && !rsp_match_valid, rsp_query_index == 6'd0 && rsp_train_index == 6'd0 && rsp_distance == 9'd0)
   `HDM_ASSERT_NOW(a_dist_range, rsp_valid && rsp_match_valid, rsp_distance <= DIST_TOP)
   `HDM_ASSERT_NEXT(a_run_busy, req_valid && req_ready && req_mode == MODE_RUN, !req_ready)

endmodule

bind hamming_descriptor_matcher_top hdm_checker u_hdm_checker (.*);
